### rtl/core/sliding_window_ols_slope_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding-window regression slope core
// Shared property forms; each use samples on i_clk and is off during reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_OLS_SLOPE_CORE_DEFINES_SVH
`define SLIDING_WINDOW_OLS_SLOPE_CORE_DEFINES_SVH

// The condition holds at every clock edge out of reset.
`define SWOLS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define SWOLS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/swols_pkg.sv
// ----------------------------------------------------------------------------
// swols_pkg
// Types, constants and the multiply-accumulate step table of the
// sliding-window regression slope core.
// ----------------------------------------------------------------------------
package swols_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int SMP_W   = 24;
    localparam int CNT_W   = 7;
    localparam int SLOPE_W = 32;
    localparam int SX_W    = SMP_W + CNT_W;
    localparam int SXX_W   = 2 * SMP_W + CNT_W - 1;
    localparam int SXY_W   = 2 * SMP_W + CNT_W;
    localparam int LO_W    = 27;
    localparam int MUL_W   = 32;
    localparam int ACC_W   = 2 * MUL_W;
    localparam int MAG_W   = 2 * SX_W - 1;
    localparam int QUO_W   = SLOPE_W + 1;

    localparam int MAC_STEPS  = 10;
    localparam int MAC_STEP_W = 4;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT  = 2'd1;

    localparam logic [CNT_W-1:0] WINDOW_LEN_RST = 7'd50;
    localparam logic [CNT_W-1:0] MIN_COUNT_RST  = 7'd5;

    localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [SMP_W-1:0] price_change;
        logic signed [SMP_W-1:0] signed_flow;
    } t_in_item;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic                      valid_res;
        logic        [CNT_W-1:0]   sample_count;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MAC,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        OPA_X,
        OPA_OX,
        OPA_SX,
        OPA_N
    } t_opa;

    typedef enum logic [3:0] {
        OPB_Y,
        OPB_OY,
        OPB_X,
        OPB_OX,
        OPB_SX,
        OPB_SY,
        OPB_SXX_LO,
        OPB_SXX_HI,
        OPB_SXY_LO,
        OPB_SXY_HI
    } t_opb;

    typedef enum logic [1:0] {
        DST_SXY,
        DST_SXX,
        DST_DEN,
        DST_NUM
    } t_dest;

    typedef struct packed {
        t_opa  a_sel;
        t_opb  b_sel;
        t_dest dest;
        logic  sub;
        logic  shift;
    } t_mac_op;

    function automatic t_mac_op mac_op(input logic [MAC_STEP_W-1:0] step);
        t_mac_op op;
        unique case (step)
            4'd0:    op = '{OPA_X,  OPB_Y,      DST_SXY, 1'b0, 1'b0};
            4'd1:    op = '{OPA_OX, OPB_OY,     DST_SXY, 1'b1, 1'b0};
            4'd2:    op = '{OPA_X,  OPB_X,      DST_SXX, 1'b0, 1'b0};
            4'd3:    op = '{OPA_OX, OPB_OX,     DST_SXX, 1'b1, 1'b0};
            4'd4:    op = '{OPA_SX, OPB_SX,     DST_DEN, 1'b1, 1'b0};
            4'd5:    op = '{OPA_SX, OPB_SY,     DST_NUM, 1'b1, 1'b0};
            4'd6:    op = '{OPA_N,  OPB_SXX_LO, DST_DEN, 1'b0, 1'b0};
            4'd7:    op = '{OPA_N,  OPB_SXX_HI, DST_DEN, 1'b0, 1'b1};
            4'd8:    op = '{OPA_N,  OPB_SXY_LO, DST_NUM, 1'b0, 1'b0};
            4'd9:    op = '{OPA_N,  OPB_SXY_HI, DST_NUM, 1'b0, 1'b1};
            default: op = '{OPA_X,  OPB_Y,      DST_NUM, 1'b0, 1'b0};
        endcase
        return op;
    endfunction

endpackage

### rtl/core/sliding_window_ols_slope_core.sv
// ----------------------------------------------------------------------------
// sliding_window_ols_slope_core
// Least-squares slope of price change on order flow over a sliding window.
//
// Each input item carries one observation (price change and order flow). The
// window keeps the last window_len pairs in a ring memory and running sums of
// x, y, x*y and x*x. One result item follows every input item.
// Input and output use valid and stall; an item moves when valid is high and
// stall is low. The configuration port writes window_len (index 0, which also
// empties the window) or min_count (index 1) when the write enable is high.
// The block takes no new item until the result of the last one has been loaded
// into the output register. The restoring divider runs only when the slope is
// valid; it produces one quotient bit per cycle over 61 + FRAC_BITS bits.
// Before it, one shared 32 by 32 multiplier and one 64-bit adder run ten
// multiply-accumulate steps.
// A result waits in the output register while the receiver stalls; the next
// item is still accepted, but its result is held back until that register
// is free. Reset empties the window and loads window_len 50, min_count 5.
// ----------------------------------------------------------------------------
`include "sliding_window_ols_slope_core_defines.svh"

module sliding_window_ols_slope_core
    import swols_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    output logic                 o_stall,
    input  t_in_item             i_data,
    output logic                 o_vld,
    input  logic                 i_stall,
    output t_out_item            o_data,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_wdata
);

    localparam int PTR_W     = $clog2(MAX_WINDOW);
    localparam int IDX_W     = PTR_W + 1;
    localparam int DIV_STEPS = MAG_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0] r_window_len;
    logic [CNT_W-1:0] r_min_count;
    logic [CNT_W-1:0] r_held;
    logic [PTR_W-1:0] r_wp;

    logic signed [SX_W-1:0]  r_sx;
    logic signed [SX_W-1:0]  r_sy;
    logic signed [SXY_W-1:0] r_sxy;
    logic        [SXX_W-1:0] r_sxx;
    logic signed [ACC_W-1:0] r_den;
    logic signed [ACC_W-1:0] r_num;

    logic [MAC_STEP_W-1:0] r_step;
    logic [DIV_CNT_W-1:0]  r_div_cnt;

    t_in_item r_item;
    t_in_item r_rd;
    t_in_item r_ring [MAX_WINDOW];

    logic signed [SMP_W-1:0] r_ox;
    logic signed [SMP_W-1:0] r_oy;
    logic signed [ACC_W-1:0] r_prod;
    t_mac_op                 r_pend;

    logic [MAG_W-1:0] r_div_num;
    logic [MAG_W-1:0] r_div_den;
    logic [MAG_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;
    logic             r_ovf;
    logic             r_neg;
    logic             r_res_ok;

    logic      r_o_vld;
    t_out_item r_o_data;

    logic [CNT_W-1:0] w_eff;
    logic             evict;
    logic [IDX_W-1:0] wp_ext;
    logic [IDX_W-1:0] held_ext;
    logic [IDX_W-1:0] old_idx;
    logic [PTR_W-1:0] rd_addr;
    logic [PTR_W-1:0] wp_next;

    t_mac_op                 cur_op;
    logic signed [MUL_W-1:0] op_a;
    logic signed [MUL_W-1:0] op_b;
    logic signed [ACC_W-1:0] acc_base;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] acc_new;

    logic             res_ok;
    logic [MAG_W:0]   rem_sh;
    logic [MAG_W+1:0] trial;
    logic             qbit;

    logic                      quo_big;
    logic signed [SLOPE_W-1:0] slope;
    logic                      out_load;

    // Effective window length and the ring slot that leaves the window.
    always_comb begin
        if (r_window_len == '0) begin
            w_eff = CNT_W'(1);
        end else if (32'(r_window_len) > 32'(MAX_WINDOW)) begin
            w_eff = CNT_W'(MAX_WINDOW);
        end else begin
            w_eff = r_window_len;
        end
        evict    = (r_held >= w_eff);
        wp_ext   = IDX_W'(r_wp);
        held_ext = IDX_W'(r_held);
        if (wp_ext >= held_ext) begin
            old_idx = wp_ext - held_ext;
        end else begin
            old_idx = wp_ext + IDX_W'(MAX_WINDOW) - held_ext;
        end
        rd_addr = PTR_W'(old_idx);
        wp_next = (r_wp == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_wp + PTR_W'(1);
    end

    // Shared multiplier operands and accumulator.
    always_comb begin
        cur_op = mac_op(r_step);
        unique case (cur_op.a_sel)
            OPA_X:  op_a = MUL_W'(r_item.signed_flow);
            OPA_OX: op_a = MUL_W'(r_ox);
            OPA_SX: op_a = MUL_W'(r_sx);
            OPA_N:  op_a = MUL_W'(r_held);
            default: op_a = '0;
        endcase
        unique case (cur_op.b_sel)
            OPB_Y:      op_b = MUL_W'(r_item.price_change);
            OPB_OY:     op_b = MUL_W'(r_oy);
            OPB_X:      op_b = MUL_W'(r_item.signed_flow);
            OPB_OX:     op_b = MUL_W'(r_ox);
            OPB_SX:     op_b = MUL_W'(r_sx);
            OPB_SY:     op_b = MUL_W'(r_sy);
            OPB_SXX_LO: op_b = MUL_W'(r_sxx[LO_W-1:0]);
            OPB_SXX_HI: op_b = MUL_W'(r_sxx[SXX_W-1:LO_W]);
            OPB_SXY_LO: op_b = MUL_W'(r_sxy[LO_W-1:0]);
            OPB_SXY_HI: op_b = MUL_W'($signed(r_sxy[SXY_W-1:LO_W]));
            default:    op_b = '0;
        endcase
        unique case (r_pend.dest)
            DST_SXY: acc_base = ACC_W'(r_sxy);
            DST_SXX: acc_base = ACC_W'(r_sxx);
            DST_DEN: acc_base = r_den;
            DST_NUM: acc_base = r_num;
            default: acc_base = '0;
        endcase
        addend  = r_pend.shift ? (r_prod <<< LO_W) : r_prod;
        acc_new = r_pend.sub ? (acc_base - addend) : (acc_base + addend);
    end

    // Restoring divider step and result formatting.
    always_comb begin
        res_ok = (r_held >= r_min_count) && (r_den > 0);
        rem_sh = {r_rem, r_div_num[MAG_W-1]};
        trial  = {1'b0, rem_sh} - {2'b00, r_div_den};
        qbit   = ~trial[MAG_W+1];

        quo_big = r_ovf | r_quo[QUO_W-1];
        if (!r_res_ok) begin
            slope = '0;
        end else if (r_neg) begin
            if (quo_big || (r_quo[SLOPE_W-1] && (|r_quo[SLOPE_W-2:0]))) begin
                slope = SLOPE_MIN;
            end else begin
                slope = -$signed(r_quo[SLOPE_W-1:0]);
            end
        end else begin
            if (quo_big || r_quo[SLOPE_W-1]) begin
                slope = SLOPE_MAX;
            end else begin
                slope = $signed(r_quo[SLOPE_W-1:0]);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_vld) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: n_state = ST_MAC;
            ST_MAC: begin
                if (r_step == MAC_STEP_W'(MAC_STEPS)) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: n_state = res_ok ? ST_DIV : ST_DONE;
            ST_DIV: begin
                if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_o_vld || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall  = (r_state != ST_IDLE);
        out_load = (r_state == ST_DONE) && (!r_o_vld || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_window_len <= WINDOW_LEN_RST;
            r_min_count  <= MIN_COUNT_RST;
            r_held       <= '0;
            r_wp         <= '0;
            r_sx         <= '0;
            r_sy         <= '0;
            r_sxy        <= '0;
            r_sxx        <= '0;
            r_den        <= '0;
            r_num        <= '0;
            r_step       <= '0;
            r_div_cnt    <= '0;
            r_o_vld      <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_UPDATE: begin
                    r_sx   <= r_sx + SX_W'(r_item.signed_flow)
                              - (evict ? SX_W'(r_rd.signed_flow) : '0);
                    r_sy   <= r_sy + SX_W'(r_item.price_change)
                              - (evict ? SX_W'(r_rd.price_change) : '0);
                    r_held <= evict ? r_held : r_held + CNT_W'(1);
                    r_wp   <= wp_next;
                    r_den  <= '0;
                    r_num  <= '0;
                    r_step <= '0;
                end
                ST_MAC: begin
                    r_step <= r_step + MAC_STEP_W'(1);
                    if (r_step != '0) begin
                        unique case (r_pend.dest)
                            DST_SXY: r_sxy <= acc_new[SXY_W-1:0];
                            DST_SXX: r_sxx <= acc_new[SXX_W-1:0];
                            DST_DEN: r_den <= acc_new;
                            DST_NUM: r_num <= acc_new;
                            default: r_num <= acc_new;
                        endcase
                    end
                end
                ST_PREP: r_div_cnt <= '0;
                ST_DIV:  r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                default: begin
                end
            endcase

            if (out_load) begin
                r_o_vld <= 1'b1;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end

            if (i_cfg_wr_en) begin
                unique case (i_cfg_idx)
                    CFG_WINDOW_LEN: begin
                        r_window_len <= i_cfg_wdata;
                        r_held       <= '0;
                        r_wp         <= '0;
                        r_sx         <= '0;
                        r_sy         <= '0;
                        r_sxy        <= '0;
                        r_sxx        <= '0;
                    end
                    CFG_MIN_COUNT: r_min_count <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_vld) begin
            r_item <= i_data;
        end
        if (r_state == ST_UPDATE) begin
            r_ox <= evict ? r_rd.signed_flow  : '0;
            r_oy <= evict ? r_rd.price_change : '0;
        end
        if ((r_state == ST_MAC) && (r_step != MAC_STEP_W'(MAC_STEPS))) begin
            r_prod <= op_a * op_b;
            r_pend <= cur_op;
        end
        if (r_state == ST_PREP) begin
            r_neg     <= r_num[ACC_W-1];
            r_div_num <= r_num[ACC_W-1] ? MAG_W'(-r_num) : MAG_W'(r_num);
            r_div_den <= MAG_W'(r_den);
            r_rem     <= '0;
            r_quo     <= '0;
            r_ovf     <= 1'b0;
            r_res_ok  <= res_ok;
        end
        if (r_state == ST_DIV) begin
            r_div_num <= r_div_num << 1;
            r_rem     <= qbit ? trial[MAG_W-1:0] : rem_sh[MAG_W-1:0];
            r_quo     <= {r_quo[QUO_W-2:0], qbit};
            r_ovf     <= r_ovf | r_quo[QUO_W-1];
        end
        if (out_load) begin
            r_o_data.slope        <= slope;
            r_o_data.valid_res    <= r_res_ok;
            r_o_data.sample_count <= r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPDATE) begin
            r_ring[r_wp] <= r_item;
        end
        r_rd <= r_ring[rd_addr];
    end

    assign o_vld  = r_o_vld;
    assign o_data = r_o_data;

    `SWOLS_ASSERT_ALWAYS(a_held_in_window, r_held <= w_eff, "held count exceeds window")
    `SWOLS_ASSERT_ALWAYS(a_wp_in_range, 32'(r_wp) < 32'(MAX_WINDOW), "write pointer out of range")
    `SWOLS_ASSERT_IMPLIES(a_invalid_zero, o_vld && !o_data.valid_res, o_data.slope == '0, "invalid slope not zero")
    `SWOLS_ASSERT_IMPLIES(a_count_nonzero, o_vld, o_data.sample_count != '0, "result with empty window")

endmodule
